// ----- rtl/sorted_key_set_top_macros.svh -----
// ----------------------------------------------------------------------------
// sorted_key_set_top_macros.svh
// Assertion macros for the sorted key set RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_TOP_MACROS_SVH
`define SORTED_KEY_SET_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKSET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SKSET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/skset_pkg.sv -----
// ----------------------------------------------------------------------------
// skset_pkg
// Shared codes and the cell control bundle of the sorted key set.
// ----------------------------------------------------------------------------
`default_nettype none

package skset_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_LISTED = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  // Broadcast to every cell: at most one bit set per cycle.
  typedef struct packed {
    logic ins;   // open a slot at the lower bound, shift upper part right
    logic rem;   // close the slot at the lower bound, shift upper part left
    logic rot;   // rotate occupied cells left by one (list readout)
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/skset_cell.sv -----
// ----------------------------------------------------------------------------
// skset_cell
// One storage cell of the chain: holds a key, compares it against the
// broadcast key and takes a neighbor's key on shift or rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module skset_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire skset_pkg::cell_ctrl_t         ctrl,
  input  wire logic signed [KEY_WIDTH-1:0]   key_in,
  input  wire logic signed [KEY_WIDTH-1:0]   left_key,
  input  wire logic signed [KEY_WIDTH-1:0]   right_key,
  input  wire logic signed [KEY_WIDTH-1:0]   head_key,
  input  wire logic                          left_lt,
  input  wire logic                          occupied,
  input  wire logic                          at_tail,
  output logic signed [KEY_WIDTH-1:0]        key_q,
  output logic                               lt,
  output logic                               eq
);
  import skset_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_next;

  assign lt = occupied && (key_q < key_in);
  assign eq = occupied && (key_q == key_in);

  always_comb begin
    key_next = key_q;
    if (ctrl.ins) begin
      // at or above the lower bound: new key lands where left neighbor is below
      if (!lt) begin
        key_next = left_lt ? key_in : left_key;
      end
    end else if (ctrl.rem) begin
      if (!lt) begin
        key_next = right_key;
      end
    end else if (ctrl.rot) begin
      key_next = at_tail ? head_key : right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_key_set_top.sv -----
// Insert and remove act on the chain when the item is accepted; a search or full result is
// registered and shows the cycle after the item is accepted.
// A list of N keys is accepted, then sent one key per cycle
// as the chain rotates its head cell into the output register; out_stall
// pauses the rotation. Next item is taken once the burst is done.
// Reset (rst, synchronous) empties the set and drops out_valid; key cells are not reset.
// ----------------------------------------------------------------------------
// sorted_key_set_top
// Ordered set of distinct signed keys in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_set_top_macros.svh"

module sorted_key_set_top #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   operation,
  input  wire logic signed [KEY_WIDTH-1:0]  key,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        kind,
  output logic                              found,
  output logic signed [KEY_WIDTH-1:0]       key_out,
  output logic                              last
);
  import skset_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  // control state
  logic             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid_next;

  // result staging
  logic                        load_out;
  logic [1:0]                  kind_d;
  logic                        found_d;
  logic signed [KEY_WIDTH-1:0] key_d;
  logic                        last_d;

  // chain
  cell_ctrl_t                  ctrl;
  logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]         cell_lt;
  logic [CAPACITY-1:0]         cell_eq;

  logic accept;
  logic slot_free;
  logic hit;
  logic full;
  logic list_last;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;

  assign hit       = |cell_eq;
  assign full      = (count == CNT_W'(CAPACITY));
  assign list_last = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // --------------------------------------------------------------------------
  // Cell chain. Occupancy follows from the count: cell i holds a key while
  // i < count. Cell 0 sees an always-below left side, so an insert at the
  // front loads the new key there; the last cell feeds itself on a left shift.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] left_k;
    logic signed [KEY_WIDTH-1:0] right_k;
    logic                        left_l;

    if (i == 0) begin : g_head
      assign left_k = key;
      assign left_l = 1'b1;
    end else begin : g_body
      assign left_k = cell_key[i-1];
      assign left_l = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_k = cell_key[i];
    end else begin : g_mid
      assign right_k = cell_key[i+1];
    end

    skset_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key_in    (key),
      .left_key  (left_k),
      .right_key (right_k),
      .head_key  (cell_key[0]),
      .left_lt   (left_l),
      .occupied  (count > CNT_W'(i)),
      .at_tail   (count == CNT_W'(i + 1)),
      .key_q     (cell_key[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer: one-shot ops in IDLE, key-per-cycle rotation in LIST while the result slot is free.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    ctrl           = '0;
    load_out       = 1'b0;
    kind_d         = KIND_SEARCH;
    found_d        = 1'b0;
    key_d          = key;
    last_d         = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_INSERT: begin
              if (!hit) begin
                if (full) begin
                  load_out = 1'b1;
                  kind_d   = KIND_FULL;
                end else begin
                  ctrl.ins   = 1'b1;
                  count_next = count + CNT_W'(1);
                end
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                ctrl.rem   = 1'b1;
                count_next = count - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              load_out = 1'b1;
              kind_d   = KIND_SEARCH;
              found_d  = hit;
            end
            OP_LIST: begin
              if (count != '0) begin
                state_next = ST_LIST;
                idx_next   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          // head of the chain is the next key in order; rotate it to the tail
          load_out = 1'b1;
          kind_d   = KIND_LISTED;
          key_d    = cell_key[0];
          last_d   = list_last;
          ctrl.rot = 1'b1;
          if (list_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // result register: loads only when the slot is free
  always_ff @(posedge clk) begin
    if (load_out) begin
      kind    <= kind_d;
      found   <= found_d;
      key_out <= key_d;
      last    <= last_d;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SKSET_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `SKSET_ASSERT_NOW(a_list_nonempty, state == ST_LIST, count != '0, "list burst on empty set")
  `SKSET_ASSERT_NEXT(a_list_ends, (state == ST_LIST) && slot_free && list_last,
                     (state == ST_IDLE) && out_valid && last, "list burst did not end on last")
  `SKSET_ASSERT_NEXT(a_insert_grows, accept && (operation == OP_INSERT) && !hit && !full,
                     count == $past(count) + CNT_W'(1), "insert did not grow the set")
  `SKSET_ASSERT_NOW(a_one_hit, 1'b1, $onehot0(cell_eq), "key stored in more than one cell")

endmodule

`default_nettype wire
